// ===== sv/stage_fov_recenter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef STAGE_FOV_RECENTER_DEFINES_SVH
`define STAGE_FOV_RECENTER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define SFR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sfr_pkg.sv =====
package sfr_pkg;

  // Fixed point and sizing
  localparam int FRAC_BITS = 4;
  localparam int MAX_BEADS = 1024;
  localparam int CFG_W     = 11;
  localparam int POS_W     = 16;
  localparam int SUM_W     = 27;
  localparam int CNT_W     = 11;
  localparam int WIDE_W    = 19;
  localparam int HALF_W    = CFG_W - 1 + FRAC_BITS;
  localparam int SCL_W     = CFG_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam int IDX_W     = 3;

  // Reset values
  localparam logic [CFG_W-1:0]        FOV_RST    = CFG_W'(101);
  localparam logic [CFG_W-1:0]        STEP_RST   = CFG_W'(500);
  localparam logic [CFG_W-1:0]        WELL_RST   = CFG_W'(2000);
  localparam logic signed [POS_W-1:0] CENTER_RST = POS_W'(16000);

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_FOV_WIDTH   = 3'd1,
    REG_FOV_HEIGHT  = 3'd2,
    REG_MAX_STEP    = 3'd3,
    REG_WELL_WIDTH  = 3'd4,
    REG_WELL_HEIGHT = 3'd5
  } reg_idx_e;

  // Request to the shared divider
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] num;
    logic [CFG_W-1:0]        den;
  } div_req_t;

endpackage

// ===== sv/sfr_div.sv =====
module sfr_div import sfr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_req_t                req_i,
  output logic                    done_o,
  output logic signed [SUM_W-1:0] quot_o
);

  logic                 busy_q;
  logic                 done_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [CFG_W-1:0]     rem_q;
  logic [CFG_W-1:0]     den_q;
  logic [SUM_W-1:0]     quo_q;
  logic [SUM_W-1:0]     mag;
  logic [CFG_W:0]       shifted;
  logic [CFG_W:0]       trial;

  // Magnitude of the dividend, sign handled at the end
  assign mag = req_i.num[SUM_W-1] ? SUM_W'(-req_i.num) : SUM_W'(req_i.num);

  // One restoring step per cycle
  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        neg_q  <= req_i.num[SUM_W-1];
        cnt_q  <= '0;
        rem_q  <= '0;
        den_q  <= req_i.den;
        quo_q  <= mag;
      end else if (busy_q) begin
        if (!trial[CFG_W]) begin
          rem_q <= trial[CFG_W-1:0];
          quo_q <= {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_q <= shifted[CFG_W-1:0];
          quo_q <= {quo_q[SUM_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Truncation toward zero: negate the unsigned quotient
  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== sv/stage_fov_recenter.sv =====
// Field-of-view recentring for a bead-tracking stage.
// Input channel (in_valid_i / in_stall_o): one item per bead position, with
// bead_present_i marking a real bead and frame_end_i the last item of a frame.
// Beads strictly inside the current view are summed, counted (up to 1024)
// and tracked for min/max in the cycle they are accepted, so ordinary items
// go in at one per cycle.
// A frame-end item starts the recentre pass, x then y: in centroid mode one
// shared restoring divider (27 steps per axis) forms sum / count, in
// bounding-box mode the midpoint is a shift. Each axis is then move limited
// and clamped to the well. Input is stalled from the frame-end item until
// its result is in the output register; an empty view skips the pass.
// Output channel (out_valid_o / out_stall_i): one result per frame, held in
// an output register. While the receiver stalls, the result holds, beads
// keep flowing in, and a following frame end waits before loading its result.
// Configuration writes (cfg_we_i) are taken at any edge, intended while idle.
// Reset (rst_ni, asynchronous, active low) restores the register defaults,
// puts the centre at the well centre and clears the frame accumulators.
module stage_fov_recenter import sfr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  // bead input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [POS_W-1:0] bead_x_i,
  input  logic signed [POS_W-1:0] bead_y_i,
  input  logic                    bead_present_i,
  input  logic                    frame_end_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [POS_W-1:0] new_center_x_o,
  output logic signed [POS_W-1:0] new_center_y_o,
  output logic [CNT_W-1:0]        beads_inside_o,
  output logic                    view_empty_o
);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_LOAD,
    ST_WAIT,
    ST_LIMIT,
    ST_CLAMP,
    ST_OUT
  } state_e;

  localparam logic signed [WIDE_W-1:0] PIX = WIDE_W'(1) << FRAC_BITS;

  // Configuration registers
  logic             mode_q;
  logic [CFG_W-1:0] fov_w_q, fov_h_q, step_q, well_w_q, well_h_q;

  // Sequencer and frame state
  state_e                    state_q;
  logic                      ax_q;
  logic                      empty_q;
  logic signed [POS_W-1:0]   center_x_q, center_y_q;
  logic signed [POS_W-1:0]   new_cx_q, new_cy_q;
  logic signed [SUM_W-1:0]   sum_x_q, sum_y_q;
  logic signed [POS_W-1:0]   min_x_q, min_y_q, max_x_q, max_y_q;
  logic [CNT_W-1:0]          count_q;
  logic signed [WIDE_W-1:0]  tgt_q;

  // Output register
  logic                      out_valid_q;
  logic signed [POS_W-1:0]   out_cx_q, out_cy_q;
  logic [CNT_W-1:0]          out_cnt_q;
  logic                      out_empty_q;

  logic                      accept, take;
  logic [HALF_W-1:0]         hx, hy;
  logic signed [POS_W+1:0]   lo_x, hi_x, lo_y, hi_y, bx_e, by_e;
  logic                      in_x, in_y;

  div_req_t                  div_req;
  logic                      div_done;
  logic signed [SUM_W-1:0]   div_quot;
  logic signed [POS_W:0]     mid_sum;
  logic signed [POS_W:0]     mid_half;

  logic [HALF_W-1:0]         half_a;
  logic [SCL_W-1:0]          well_a;
  logic signed [WIDE_W-1:0]  cur_a, step_w, diff, half_w, well_w, clamp_lo, clamp_hi;
  logic                      out_free;

  // Config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      fov_w_q  <= FOV_RST;
      fov_h_q  <= FOV_RST;
      step_q   <= STEP_RST;
      well_w_q <= WELL_RST;
      well_h_q <= WELL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:        mode_q   <= cfg_data_i[0];
        REG_FOV_WIDTH:   fov_w_q  <= cfg_data_i;
        REG_FOV_HEIGHT:  fov_h_q  <= cfg_data_i;
        REG_MAX_STEP:    step_q   <= cfg_data_i;
        REG_WELL_WIDTH:  well_w_q <= cfg_data_i;
        REG_WELL_HEIGHT: well_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Inside-view test, strict on both sides
  assign hx   = {fov_w_q[CFG_W-1:1], {FRAC_BITS{1'b0}}};
  assign hy   = {fov_h_q[CFG_W-1:1], {FRAC_BITS{1'b0}}};
  assign bx_e = (POS_W+2)'(bead_x_i);
  assign by_e = (POS_W+2)'(bead_y_i);
  assign lo_x = (POS_W+2)'(center_x_q) - $signed({4'b0, hx});
  assign hi_x = (POS_W+2)'(center_x_q) + $signed({4'b0, hx});
  assign lo_y = (POS_W+2)'(center_y_q) - $signed({4'b0, hy});
  assign hi_y = (POS_W+2)'(center_y_q) + $signed({4'b0, hy});
  assign in_x = (bx_e > lo_x) && (bx_e < hi_x);
  assign in_y = (by_e > lo_y) && (by_e < hi_y);

  assign in_stall_o = (state_q != ST_ACC);
  assign accept     = in_valid_i && !in_stall_o;
  assign take       = accept && bead_present_i && in_x && in_y &&
                      (count_q < CNT_W'(MAX_BEADS));

  // Bounding-box midpoint, halved toward zero
  assign mid_sum  = ax_q ? (POS_W+1)'(min_y_q) + (POS_W+1)'(max_y_q)
                         : (POS_W+1)'(min_x_q) + (POS_W+1)'(max_x_q);
  assign mid_half = $signed(mid_sum + {{POS_W{1'b0}}, mid_sum[POS_W]}) >>> 1;

  // Divider request: centroid for the current axis
  always_comb begin
    div_req.start = (state_q == ST_LOAD) && (count_q != '0) && !mode_q;
    div_req.num   = ax_q ? sum_y_q : sum_x_q;
    div_req.den   = count_q;
  end

  sfr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Per-axis move limit and well clamp operands
  assign half_a   = ax_q ? hy : hx;
  assign well_a   = ax_q ? {well_h_q, {FRAC_BITS{1'b0}}} : {well_w_q, {FRAC_BITS{1'b0}}};
  assign cur_a    = ax_q ? WIDE_W'(center_y_q) : WIDE_W'(center_x_q);
  assign step_w   = $signed(WIDE_W'({step_q, {FRAC_BITS{1'b0}}}));
  assign half_w   = $signed(WIDE_W'(half_a));
  assign well_w   = $signed(WIDE_W'(well_a));
  assign diff     = tgt_q - cur_a;
  assign clamp_lo = (tgt_q - half_w < 0) ? half_w - PIX : tgt_q;
  assign clamp_hi = (clamp_lo + half_w > well_w) ? well_w - half_w - PIX : clamp_lo;

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer, accumulators, centre and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      ax_q        <= 1'b0;
      empty_q     <= 1'b0;
      center_x_q  <= CENTER_RST;
      center_y_q  <= CENTER_RST;
      new_cx_q    <= '0;
      new_cy_q    <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      min_x_q     <= '0;
      min_y_q     <= '0;
      max_x_q     <= '0;
      max_y_q     <= '0;
      count_q     <= '0;
      tgt_q       <= '0;
      out_valid_q <= 1'b0;
      out_cx_q    <= '0;
      out_cy_q    <= '0;
      out_cnt_q   <= '0;
      out_empty_q <= 1'b0;
    end else begin
      // taken result leaves, unless the next one is loaded in ST_OUT
      if (out_valid_q && !out_stall_i && state_q != ST_OUT) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_ACC: begin
          if (take) begin
            if (count_q == '0) begin
              min_x_q <= bead_x_i;
              max_x_q <= bead_x_i;
              min_y_q <= bead_y_i;
              max_y_q <= bead_y_i;
            end else begin
              if (bead_x_i < min_x_q) min_x_q <= bead_x_i;
              if (bead_x_i > max_x_q) max_x_q <= bead_x_i;
              if (bead_y_i < min_y_q) min_y_q <= bead_y_i;
              if (bead_y_i > max_y_q) max_y_q <= bead_y_i;
            end
            sum_x_q <= sum_x_q + SUM_W'(bead_x_i);
            sum_y_q <= sum_y_q + SUM_W'(bead_y_i);
            count_q <= count_q + 1'b1;
          end
          if (accept && frame_end_i) begin
            ax_q    <= 1'b0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (count_q == '0) begin
            empty_q  <= 1'b1;
            new_cx_q <= center_x_q;
            new_cy_q <= center_y_q;
            state_q  <= ST_OUT;
          end else begin
            empty_q <= 1'b0;
            if (mode_q) begin
              tgt_q   <= WIDE_W'(mid_half);
              state_q <= ST_LIMIT;
            end else begin
              state_q <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (div_done) begin
            tgt_q   <= div_quot[WIDE_W-1:0];
            state_q <= ST_LIMIT;
          end
        end
        ST_LIMIT: begin
          if (diff > step_w) tgt_q <= cur_a + step_w;
          else if (-diff > step_w) tgt_q <= cur_a - step_w;
          state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          if (!ax_q) begin
            new_cx_q <= clamp_hi[POS_W-1:0];
            ax_q     <= 1'b1;
            state_q  <= ST_LOAD;
          end else begin
            new_cy_q <= clamp_hi[POS_W-1:0];
            state_q  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_cx_q    <= new_cx_q;
            out_cy_q    <= new_cy_q;
            out_cnt_q   <= count_q;
            out_empty_q <= empty_q;
            center_x_q  <= new_cx_q;
            center_y_q  <= new_cy_q;
            sum_x_q     <= '0;
            sum_y_q     <= '0;
            min_x_q     <= '0;
            min_y_q     <= '0;
            max_x_q     <= '0;
            max_y_q     <= '0;
            count_q     <= '0;
            state_q     <= ST_ACC;
          end
        end
        default: state_q <= ST_ACC;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_center_x_o = out_cx_q;
  assign new_center_y_o = out_cy_q;
  assign beads_inside_o = out_cnt_q;
  assign view_empty_o   = out_empty_q;

endmodule

// ===== sv/sfr_chk.sv =====
`include "stage_fov_recenter_defines.svh"

module sfr_chk import sfr_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    frame_end_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [POS_W-1:0] new_center_x_o,
  input logic signed [POS_W-1:0] new_center_y_o,
  input logic [CNT_W-1:0]        beads_inside_o,
  input logic                    view_empty_o
);

  logic                       in_take;
  logic [2*POS_W+CNT_W+1:0]   res;

  assign in_take = in_valid_i && !in_stall_o;
  assign res     = {out_valid_o, new_center_x_o, new_center_y_o, beads_inside_o, view_empty_o};

  // A stalled result stays valid and unchanged
  `SFR_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, $stable(res), "stalled result changed")

  // Empty flag agrees with the bead count
  `SFR_ASSERT(a_empty_cnt, out_valid_o, view_empty_o == (beads_inside_o == '0), "bad empty flag")

  // Count never passes the saturation limit
  `SFR_ASSERT(a_cnt_sat, out_valid_o, beads_inside_o <= CNT_W'(MAX_BEADS), "count too high")

  // A frame end starts the recentre pass, so input stalls next cycle
  `SFR_ASSERT_NXT(a_fe_stall, in_take && frame_end_i, in_stall_o, "no stall after frame end")

endmodule

bind stage_fov_recenter sfr_chk u_sfr_chk (.*);
